### sv/tss_pkg.sv
// Shared types and constants for the two-stack shared store.
// No dependencies; imported by twin_stack_shared_store.
package tss_pkg;

  localparam int DEF_STORE_DEPTH = 32;
  localparam int WORD_W          = 32;
  localparam int COUNT_W         = 6;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_PEEK = 2'd2;

  typedef struct packed {
    logic [1:0]               command;
    logic                     stack_select;
    logic signed [WORD_W-1:0] push_value;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] top_value;
    logic                     stack_empty;
    logic                     overflow;
    logic [COUNT_W-1:0]       low_count;
    logic [COUNT_W-1:0]       high_count;
  } out_t;

  // Beat in flight between the memory access and the output register
  typedef struct packed {
    logic                     use_rdata;
    logic signed [WORD_W-1:0] value;
    logic                     stack_empty;
    logic                     overflow;
    logic [COUNT_W-1:0]       low_count;
    logic [COUNT_W-1:0]       high_count;
  } pend_t;

endpackage

### sv/tss_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module tss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/twin_stack_shared_store.sv
// Two stacks in one store: low stack grows up from entry 0, high stack down from the top.
// Beats pass a pending register, then the output register; one item per cycle sustained
// while out_stall is low, set by the at-most-one RAM access (push write, pop/peek read).
// Reset (rst_n, synchronous) clears both counts and the pipeline valids;
// store contents are not cleared and need no clearing pass.
// Depends on tss_pkg and tss_ram.
module twin_stack_shared_store #(
  parameter int STORE_DEPTH = tss_pkg::DEF_STORE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  tss_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output tss_pkg::out_t out_data
);

  import tss_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);

  logic [CW-1:0] low_cnt_r, low_cnt_nxt;
  logic [CW-1:0] high_cnt_r, high_cnt_nxt;
  logic [CW:0]   cnt_sum;
  logic          full;
  logic          push_ok;
  logic          ovf;
  logic [CW-1:0] sel_cnt;
  logic          sel_empty;

  logic          p_valid_r;
  pend_t         p_beat_r;
  pend_t         p_beat_nxt;
  logic          p_move;
  logic          accept;

  logic          out_valid_r;
  out_t          out_data_r;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  assign p_move   = !out_valid_r || !out_stall;
  assign in_stall = p_valid_r && !p_move;
  assign accept   = in_valid && !in_stall;

  assign cnt_sum = {1'b0, low_cnt_r} + {1'b0, high_cnt_r};
  assign full    = cnt_sum >= (CW+1)'(STORE_DEPTH);

  always_comb begin
    low_cnt_nxt  = low_cnt_r;
    high_cnt_nxt = high_cnt_r;
    push_ok      = 1'b0;
    ovf          = 1'b0;
    case (in_data.command)
      CMD_PUSH: begin
        if (full) begin
          ovf = 1'b1;
        end else begin
          push_ok = 1'b1;
          if (in_data.stack_select) begin
            high_cnt_nxt = high_cnt_r + 1'b1;
          end else begin
            low_cnt_nxt = low_cnt_r + 1'b1;
          end
        end
      end
      CMD_POP: begin
        if (in_data.stack_select) begin
          if (high_cnt_r != '0) high_cnt_nxt = high_cnt_r - 1'b1;
        end else begin
          if (low_cnt_r != '0) low_cnt_nxt = low_cnt_r - 1'b1;
        end
      end
      default: ; // peek and the unused code change nothing
    endcase
  end

  assign sel_cnt   = in_data.stack_select ? high_cnt_nxt : low_cnt_nxt;
  assign sel_empty = (sel_cnt == '0);

  // Push: top is the word just written, no read needed
  assign ram_we    = accept && push_ok;
  assign ram_waddr = in_data.stack_select ? AW'(CW'(STORE_DEPTH - 1) - high_cnt_r)
                                          : AW'(low_cnt_r);
  assign ram_re    = accept && !push_ok && !sel_empty;
  assign ram_raddr = in_data.stack_select ? AW'(CW'(STORE_DEPTH) - high_cnt_nxt)
                                          : AW'(low_cnt_nxt - 1'b1);

  always_comb begin
    p_beat_nxt.use_rdata   = !push_ok && !sel_empty;
    p_beat_nxt.value       = push_ok ? in_data.push_value : '0;
    p_beat_nxt.stack_empty = sel_empty;
    p_beat_nxt.overflow    = ovf;
    p_beat_nxt.low_count   = COUNT_W'(low_cnt_nxt);
    p_beat_nxt.high_count  = COUNT_W'(high_cnt_nxt);
  end

  tss_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.push_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_cnt_r   <= '0;
      high_cnt_r  <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        low_cnt_r  <= low_cnt_nxt;
        high_cnt_r <= high_cnt_nxt;
      end
      if (!in_stall) begin
        p_valid_r <= in_valid;
      end
      if (p_move) begin
        out_valid_r <= p_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_beat_r <= p_beat_nxt;
    end
    if (p_move && p_valid_r) begin
      out_data_r.top_value   <= p_beat_r.use_rdata ? ram_rdata : p_beat_r.value;
      out_data_r.stack_empty <= p_beat_r.stack_empty;
      out_data_r.overflow    <= p_beat_r.overflow;
      out_data_r.low_count   <= p_beat_r.low_count;
      out_data_r.high_count  <= p_beat_r.high_count;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
